@@ design/salru_pkg.sv @@
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative LRU tag directory.
// ----------------------------------------------------------------------------
package salru_pkg;

  // configuration port
  localparam int CFG_W  = 4;   // widest register
  localparam int CFG_IW = 2;   // register index width

  localparam logic [CFG_IW-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd5;
  localparam logic [CFG_W-1:0] RST_SET_BITS    = 4'd10;
  localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

  // raw set index: the set width register is at most 2^CFG_W - 1
  localparam int IDXW = (1 << CFG_W) - 1;

  // access kinds
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_EVAL
  } st_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;      // write a zero row, advance clear pointer
    logic capture;  // latch the beat, decode address
    logic red_step; // one set-index reduction step
    logic rd_en;    // read the set row
    logic eval;     // resolve access, write back, emit result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic red_done;
  } sts_t;

endpackage

@@ design/salru_ram.sv @@
// ----------------------------------------------------------------------------
// salru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/salru_ctrl.sv @@
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer: clearing pass after reset, then decode, reduce, read, resolve.
// ----------------------------------------------------------------------------
module salru_ctrl
  import salru_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (start) state_nxt = S_REDUCE;
      S_REDUCE: if (sts.red_done) state_nxt = S_READ;
      S_READ:   state_nxt = S_EVAL;
      S_EVAL:   state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_CLEAR:  cmd.clr = 1'b1;
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_REDUCE: cmd.red_step = 1'b1;
      S_READ:   cmd.rd_en = 1'b1;
      S_EVAL:   cmd.eval = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ design/salru_dp.sv @@
// ----------------------------------------------------------------------------
// salru_dp
// Datapath: config registers, address decode, set reduction, set row RAM,
// hit/fill/victim resolution with rank update, result registers.
// ----------------------------------------------------------------------------
module salru_dp
  import salru_pkg::*;
#(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_cmd,
  input  logic [ADDR_BITS-1:0]  in_address,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [2:0]            out_way,
  output logic                  out_evicted,
  output logic [ADDR_BITS-1:0]  out_evicted_tag
);

  localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;  // way and rank width
  localparam int NWW   = $clog2(MAX_WAYS + 1);
  localparam int ROFF  = MAX_WAYS;
  localparam int TOFF  = MAX_WAYS * (1 + WW);
  localparam int ROW_W = MAX_WAYS * (1 + WW + ADDR_BITS);
  localparam bit POW2  = ((MAX_SETS & (MAX_SETS - 1)) == 0);

  // ---- configuration ----
  logic [CFG_W-1:0] offset_r, index_r, ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= RST_OFFSET_BITS;
      index_r  <= RST_SET_BITS;
      ways_r   <= RST_WAYS_IN_USE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: offset_r <= cfg_wdata;
        CFG_SET_BITS:    index_r  <= cfg_wdata;
        CFG_WAYS_IN_USE: ways_r   <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // ---- address decode at capture ----
  logic [CFG_W:0]             shamt;
  logic [IDXW+ADDR_BITS-1:0]  addr_sh;
  logic [IDXW:0]              idx_mask;
  logic [IDXW-1:0]            idx_dec;
  logic [ADDR_BITS-1:0]       tag_dec;

  always_comb begin
    shamt    = {1'b0, offset_r} + {1'b0, index_r};
    addr_sh  = {{IDXW{1'b0}}, in_address} >> offset_r;
    idx_mask = ((IDXW+1)'(1) << index_r) - (IDXW+1)'(1);
    idx_dec  = addr_sh[IDXW-1:0] & idx_mask[IDXW-1:0];
    tag_dec  = in_address >> shamt;
  end

  logic                 cmd_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [IDXW-1:0]      idx_r;
  logic [SW-1:0]        set_addr;

  // ---- set index modulo MAX_SETS ----
  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          idx_r <= idx_dec;
        end
      end
      assign sts.red_done = 1'b1;
      assign set_addr     = SW'(idx_r & IDXW'(MAX_SETS - 1));
    end else begin : g_recip
      // step 1: quotient by reciprocal multiply, low by at most one
      // step 2: multiply back, subtract, correct once
      localparam int QS = IDXW + SW;
      localparam int MW = IDXW + 1;
      localparam int PW = IDXW + MW;
      localparam logic [MW-1:0] RECIP = MW'((64'd1 << QS) / MAX_SETS);
      logic            ph_r;
      logic [IDXW-1:0] q_r;
      logic [PW-1:0]   prod;
      logic [IDXW-1:0] q_est;
      logic [QS-1:0]   qd;
      logic [QS-1:0]   rem_w;
      logic [QS-1:0]   rem_fix;

      always_comb begin
        prod    = PW'(idx_r) * PW'(RECIP);
        q_est   = IDXW'(prod >> QS);
        qd      = QS'(q_r) * QS'(MAX_SETS);
        rem_w   = QS'(idx_r) - qd;
        rem_fix = (rem_w >= QS'(MAX_SETS)) ? rem_w - QS'(MAX_SETS) : rem_w;
      end

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          idx_r <= idx_dec;
          ph_r  <= 1'b0;
        end else if (cmd.red_step) begin
          if (!ph_r) begin
            q_r  <= q_est;
            ph_r <= 1'b1;
          end else begin
            idx_r <= IDXW'(rem_fix);
          end
        end
      end

      assign sts.red_done = ph_r;
      assign set_addr     = SW'(idx_r);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      tag_r <= tag_dec;
    end
  end

  // ---- clearing pass pointer ----
  logic [SW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + SW'(1);
    end
  end

  assign sts.clr_last = (clr_r == SW'(MAX_SETS - 1));

  // ---- set row RAM: {tags, ranks, valids} ----
  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata, row_rd, row_new;
  logic             upd;

  assign ram_we    = cmd.clr | upd;
  assign ram_waddr = cmd.clr ? clr_r : set_addr;
  assign ram_wdata = cmd.clr ? '0 : row_new;

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (set_addr),
    .rdata (row_rd)
  );

  // ---- unpack and resolve ----
  logic [MAX_WAYS-1:0]  v, use_v, hit_v, inv_v, cand;
  logic [WW-1:0]        rk [MAX_WAYS];
  logic [ADDR_BITS-1:0] tg [MAX_WAYS];
  logic [NWW-1:0]       nways;

  function automatic logic [WW-1:0] lowest(input logic [MAX_WAYS-1:0] vec);
    logic [WW-1:0] r;
    r = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (vec[i]) r = WW'(i);
    end
    return r;
  endfunction

  always_comb begin
    if (ways_r == '0) begin
      nways = NWW'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      nways = NWW'(MAX_WAYS);
    end else begin
      nways = NWW'(ways_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      v[i]     = row_rd[i];
      rk[i]    = row_rd[ROFF + i*WW +: WW];
      tg[i]    = row_rd[TOFF + i*ADDR_BITS +: ADDR_BITS];
      use_v[i] = (NWW'(i) < nways);
      hit_v[i] = use_v[i] & v[i] & (tg[i] == tag_r);
      inv_v[i] = use_v[i] & ~v[i];
    end
  end

  // victim: largest rank among ways in use, lowest way on a tie;
  // narrowed one rank bit at a time from the top
  always_comb begin
    logic [MAX_WAYS-1:0] sel;
    cand = use_v;
    for (int b = WW - 1; b >= 0; b--) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        sel[i] = cand[i] & rk[i][b];
      end
      if (|sel) cand = sel;
    end
  end

  logic          hit, is_fill, is_ev;
  logic [WW-1:0] hw, fw, vw, w;
  logic [WW:0]   old_rk;

  always_comb begin
    hw      = lowest(hit_v);
    fw      = lowest(inv_v);
    vw      = lowest(cand);
    hit     = |hit_v;
    is_fill = !hit && (|inv_v);
    is_ev   = !hit && !(|inv_v);
    w       = hit ? hw : (is_fill ? fw : vw);
    if (hit) begin
      old_rk = {1'b0, rk[hw]};
    end else if (is_fill) begin
      old_rk = (WW+1)'(MAX_WAYS);
    end else begin
      old_rk = {1'b0, rk[vw]};
    end
    upd = cmd.eval && (cmd_r == CMD_LOAD);
  end

  // promote w: younger valid ways in use age by one, w becomes rank 0
  always_comb begin
    row_new = row_rd;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WW'(i) == w) begin
        row_new[ROFF + i*WW +: WW] = '0;
        if (!hit) begin
          row_new[i]                            = 1'b1;
          row_new[TOFF + i*ADDR_BITS +: ADDR_BITS] = tag_r;
        end
      end else if (use_v[i] && v[i] && ({1'b0, rk[i]} < old_rk)
                   && ({1'b0, rk[i]} < (WW+1)'(MAX_WAYS - 1))) begin
        row_new[ROFF + i*WW +: WW] = rk[i] + WW'(1);
      end
    end
  end

  // ---- result registers ----
  logic                 out_valid_r, hit_r, ev_r;
  logic [2:0]           way_r;
  logic [ADDR_BITS-1:0] evtag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.eval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_r   <= hit;
      way_r   <= ((cmd_r == CMD_STORE) && !hit) ? 3'd0 : 3'(w);
      ev_r    <= (cmd_r == CMD_LOAD) && is_ev;
      evtag_r <= ((cmd_r == CMD_LOAD) && is_ev) ? tg[vw] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_way         = way_r;
  assign out_evicted     = ev_r;
  assign out_evicted_tag = evtag_r;

endmodule

@@ design/set_assoc_lru_tag_directory.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_directory
// Tag directory of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// A beat taken in idle passes the set reduction (a mask when MAX_SETS is a
// power of two, else a reciprocal multiply for the quotient, then multiply
// back and correct), the row read and the resolve; the result is registered.
// No new access is taken until the current one is through the row RAM read,
// resolve and write-back sequence; busy is low again as the result shows.
// Reset: synchronous, active low; afterwards a clearing pass writes all
// MAX_SETS rows, one per cycle, with busy high. Results cannot be stalled.
//
// Organization
//   salru_ctrl : state machine (clear, idle, reduce, read, evaluate).
//   salru_dp   : config registers, address decode, set reduction, row RAM,
//                hit / fill / victim logic and the recency rank update.
//   salru_ram  : one row per set holding every way's valid bit, rank and tag,
//                so one read sees the whole set and one write updates it.
//
// Replacement
//   Each valid way carries a rank, 0 = most recent. A load hit, fill or
//   eviction makes its way rank 0 and ages every valid way in use that was
//   younger. A load miss fills the lowest invalid way in use, else evicts
//   the way of largest rank (lowest way on a tie). Stores probe only.
module set_assoc_lru_tag_directory
  import salru_pkg::*;
#(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // access beat
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [ADDR_BITS-1:0] in_address,
  // result beat, one cycle strobe
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [2:0]           out_way,
  output logic                 out_evicted,
  output logic [ADDR_BITS-1:0] out_evicted_tag
);

  cmd_t cmd;
  sts_t sts;

  salru_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  salru_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_way         (out_way),
    .out_evicted     (out_evicted),
    .out_evicted_tag (out_evicted_tag)
  );

endmodule

@@ sim/tb_set_assoc_lru_tag_directory.sv @@
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_tag_directory
// Self-checking bench for the set-associative LRU tag directory. A local
// model of the directory holds its own valid bits, tags and age ranks. It
// predicts hit, way and eviction for every access beat taken. A monitor
// compares each result strobe field by field against the oldest prediction.
// Directed corner tests come first, then phased random traffic over a range
// of geometries.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_tag_directory
  import salru_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SETS       = 1024;
  localparam int NUM_WAYS       = 8;
  localparam int ADDR_W         = 24;
  localparam int WATCHDOG_LIMIT = 4000;  // covers the post-reset clearing pass
  localparam int DRAIN_CYCLES   = 8;     // settling time after the last result beat
  localparam int RAND_PHASES    = 13;
  localparam int PHASE_BEATS    = 125;

  // one expected result beat
  typedef struct packed {
    logic              hit;
    logic [2:0]        way;
    logic              evicted;
    logic [ADDR_W-1:0] evicted_tag;
  } dir_result_t;

  // Every input starts at a known value.
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CFG_IW-1:0] cfg_index  = CFG_OFFSET_BITS;
  logic [CFG_W-1:0]  cfg_wdata  = '0;
  logic              start      = 1'b0;
  logic              in_cmd     = CMD_LOAD;
  logic [ADDR_W-1:0] in_address = '0;
  logic              busy;
  logic              out_valid;
  logic              out_hit;
  logic [2:0]        out_way;
  logic              out_evicted;
  logic [ADDR_W-1:0] out_evicted_tag;

  // Directory model: one row of NUM_WAYS lines per set, set-major.
  bit                line_ok   [NUM_SETS*NUM_WAYS];
  bit [ADDR_W-1:0]   line_tag_q[NUM_SETS*NUM_WAYS];
  bit [2:0]          age_q     [NUM_SETS*NUM_WAYS];   // 0 = most recent
  logic [CFG_W-1:0]  dir_offset_bits = RST_OFFSET_BITS;
  logic [CFG_W-1:0]  dir_set_width   = RST_SET_BITS;
  logic [CFG_W-1:0]  dir_ways        = RST_WAYS_IN_USE;

  dir_result_t pending_results[$];   // predictions waiting for their beat
  int          errors      = 0;
  int          idle_cycles = 0;
  bit          gaps_on     = 1'b0;   // random idle bursts on the input side

  set_assoc_lru_tag_directory #(
    .MAX_SETS  (NUM_SETS),
    .MAX_WAYS  (NUM_WAYS),
    .ADDR_BITS (ADDR_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_way         (out_way),
    .out_evicted     (out_evicted),
    .out_evicted_tag (out_evicted_tag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Make way w the most recent. Valid ways in use that were younger than its
  // old rank age by one; ranks saturate at NUM_WAYS-1. Ways beyond the ones
  // in use are left alone.
  function automatic void make_mru(int base, int nw, int w, int old_rank);
    int i;
    for (i = 0; i < nw; i++) begin
      if (i == w || !line_ok[base+i]) continue;
      if (age_q[base+i] < old_rank && age_q[base+i] < NUM_WAYS - 1)
        age_q[base+i]++;
    end
    age_q[base+w] = '0;
  endfunction

  // Predict the result of one access and update the directory model.
  function automatic dir_result_t directory_access(logic cmd, logic [ADDR_W-1:0] addr);
    dir_result_t     r;
    bit [63:0]       a;
    bit [63:0]       set_raw;
    logic [ADDR_W-1:0] tg;
    int              sh, nw, base, w, best, i;
    bit              found;
    a  = 64'(addr);
    // sum in int: 15 + 15 must not wrap in four bits
    sh = int'(dir_offset_bits) + int'(dir_set_width);
    set_raw = (a >> dir_offset_bits) & ((64'd1 << dir_set_width) - 64'd1);
    tg = ADDR_W'(a >> sh);   // zero once offset plus index covers the address
    // zero ways means one; more than the array holds saturates
    nw = (dir_ways == 0) ? 1 : (dir_ways > NUM_WAYS) ? NUM_WAYS : int'(dir_ways);
    base  = int'(set_raw % NUM_SETS) * NUM_WAYS;   // oversized index wraps
    r     = '0;
    w     = 0;
    found = 1'b0;
    for (i = 0; i < nw; i++) begin
      if (line_ok[base+i] && line_tag_q[base+i] == tg) begin
        r.hit = 1'b1;
        w     = i;
        break;
      end
    end
    if (cmd == CMD_LOAD) begin
      if (r.hit) begin
        make_mru(base, nw, w, int'(age_q[base+w]));
      end else begin
        for (i = 0; i < nw; i++) begin
          if (!line_ok[base+i]) begin
            w     = i;
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          line_ok[base+w]    = 1'b1;
          line_tag_q[base+w] = tg;
          make_mru(base, nw, w, NUM_WAYS);
        end else begin
          // oldest way in use, lowest way on a tie
          best = 0;
          for (i = 1; i < nw; i++)
            if (age_q[base+i] > age_q[base+best]) best = i;
          w                  = best;
          r.evicted          = 1'b1;
          r.evicted_tag      = line_tag_q[base+w];
          line_tag_q[base+w] = tg;
          make_mru(base, nw, w, int'(age_q[base+w]));
        end
      end
    end
    // a store miss reports way 0, already the default
    r.way = w[2:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  // Results cannot be stalled: every strobe is a beat. Outputs are sampled
  // at the edge, before the block's own updates land.
  always @(posedge clk) begin
    dir_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no access outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", out_hit, want.hit));
        if (out_way !== want.way)
          report_mismatch($sformatf("way %0d, expected %0d", out_way, want.way));
        if (out_evicted !== want.evicted)
          report_mismatch($sformatf("evicted %b, expected %b", out_evicted, want.evicted));
        if (out_evicted_tag !== want.evicted_tag)
          report_mismatch($sformatf("evicted_tag %h, expected %h",
                                    out_evicted_tag, want.evicted_tag));
      end
    end
  end

  // Watchdog: cycles in a row with neither an access nor a result beat.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One access beat. start stays high after the beat is taken so that a
  // back-to-back caller never lowers and raises it in one step; anyone who
  // pauses lowers it first.
  task automatic send_access(logic cmd, logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(directory_access(cmd, addr));
  endtask

  // Stop issuing and wait until every result is in and the block is idle.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_OFFSET_BITS: dir_offset_bits = val;
      CFG_SET_BITS:    dir_set_width   = val;
      CFG_WAYS_IN_USE: dir_ways        = val;
      default: ;
    endcase
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic set_config(logic [CFG_W-1:0] off, logic [CFG_W-1:0] ib,
                            logic [CFG_W-1:0] ways);
    wait_quiet();
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_SET_BITS, ib);
    write_reg(CFG_WAYS_IN_USE, ways);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset geometry: 32-byte blocks, 1024 sets, direct mapped.
  task automatic test_reset_config();
    send_access(CMD_LOAD,  24'h000000);   // cold miss fills way 0
    send_access(CMD_LOAD,  24'h00001F);   // same block: hit
    send_access(CMD_STORE, 24'hFFFFFF);   // store miss, no allocate
    send_access(CMD_LOAD,  24'hFFFFFF);   // top set, top tag
    send_access(CMD_STORE, 24'hFFFFE0);   // store hit on that line
    send_access(CMD_LOAD,  24'h008000);   // set 0, new tag: evicts tag 0
  endtask

  // One set, eight ways, tag = address: fill, promote, evict in LRU order.
  task automatic test_lru_replacement();
    int t;
    set_config(4'd0, 4'd0, 4'd8);
    for (t = 1; t <= 8; t++) send_access(CMD_LOAD, ADDR_W'(t));
    send_access(CMD_LOAD,  24'h000003);   // hit makes way 2 most recent
    send_access(CMD_STORE, 24'h000001);   // store hit leaves tag 1 oldest
    send_access(CMD_LOAD,  24'hFFFFFF);   // evicts tag 1
    send_access(CMD_LOAD,  24'h00000A);   // evicts tag 2
  endtask

  task automatic test_config_corners();
    // zero ways acts as one; the other seven keep their lines
    set_config(4'd0, 4'd0, 4'd0);
    send_access(CMD_LOAD, 24'h000123);
    // ways above the array saturate; the parked ways count again
    set_config(4'd0, 4'd0, 4'd15);
    send_access(CMD_LOAD, 24'h000005);
    send_access(CMD_LOAD, 24'h000777);
    // offset plus index past the address: tag is 0, the index is wider than the array
    set_config(4'd15, 4'd15, 4'd4);
    send_access(CMD_LOAD,  24'hABCDEF);
    send_access(CMD_STORE, 24'h123456);
    // largest legal block and set count
    set_config(4'd12, 4'd10, 4'd8);
    send_access(CMD_LOAD,  24'hFFFFFF);
    send_access(CMD_STORE, 24'hFFFFFF);
    // index wider than the array: raw set 0xC00 folds onto set 0
    set_config(4'd0, 4'd12, 4'd2);
    send_access(CMD_LOAD, 24'h000000);
    send_access(CMD_LOAD, 24'h000C00);
  endtask

  // Phased random traffic. Each phase picks a geometry and a small pool of
  // tags aimed at a few sets, so fills, hits and evictions all come often;
  // a slice of fully random addresses rides along as noise.
  task automatic test_random_traffic();
    bit [63:0]        tag_pool[12];
    bit [63:0]        a;
    bit [63:0]        set_raw;
    int               ph, n, k, pool_n, sh;
    logic [CFG_W-1:0] off, ib, wy;
    logic             cmd;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin off = 4'd12; ib = 4'd10; wy = 4'd8;  end
        1: begin off = 4'd0;  ib = 4'd0;  wy = 4'd1;  end
        2: begin off = 4'd5;  ib = 4'd10; wy = 4'd4;  end
        3: begin off = 4'd15; ib = 4'd15; wy = 4'd15; end
        4: begin off = 4'd2;  ib = 4'd3;  wy = 4'd0;  end
        default: begin
          off = CFG_W'($urandom_range(0, 12));
          ib  = CFG_W'($urandom_range(0, 10));
          wy  = CFG_W'($urandom_range(1, 8));
          // now and then leave the documented ranges
          if ($urandom_range(0, 3) == 0) ib = CFG_W'($urandom_range(11, 15));
          if ($urandom_range(0, 3) == 0) wy = CFG_W'($urandom_range(9, 15));
        end
      endcase
      set_config(off, ib, wy);
      pool_n = $urandom_range(2, 12);
      for (k = 0; k < 12; k++) tag_pool[k] = 64'($urandom);
      sh = int'(off) + int'(ib);
      for (n = 0; n < PHASE_BEATS; n++) begin
        // alternate stretches with and without idling; the last phase has none
        if (n % 40 == 0)
          gaps_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
        cmd = ($urandom_range(0, 3) == 0) ? CMD_STORE : CMD_LOAD;
        if ($urandom_range(0, 7) == 0) begin
          a = 64'($urandom);
        end else begin
          // few low sets; high index bits only matter when the index wraps
          set_raw = 64'(($urandom & 32'hFC00) | $urandom_range(0, 3));
          a = (tag_pool[$urandom_range(0, pool_n - 1)] << sh)
            | ((set_raw & ((64'd1 << ib) - 64'd1)) << off)
            | (64'($urandom) & ((64'd1 << off) - 64'd1));
        end
        send_access(cmd, a[ADDR_W-1:0]);
      end
    end
    gaps_on = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait_quiet();            // ride out the clearing pass
    test_reset_config();
    test_lru_replacement();
    test_config_corners();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
